// ----- design/dcdiw_pkg.sv -----
// -----------------------------------------------------------------------------
// dcdiw_pkg
// Shared widths, constants and constant-divisor helpers for the day count to
// date and ISO week converter.
// -----------------------------------------------------------------------------
package dcdiw_pkg;

    // default width of the incoming day count
    localparam int DAY_BITS_DEF = 32;

    // result field widths
    localparam int YEAR_W      = 24;
    localparam int MONTH_W     = 4;
    localparam int MDAY_W      = 5;
    localparam int WYEAR_W     = 23;
    localparam int WEEK_W      = 6;
    localparam int OUT_TDATA_W = 64;

    // day-of-era values: 0 .. 146096
    localparam int DOE_W = 18;
    localparam logic [DOE_W-1:0] ERA_DAYS = 18'd146097;
    localparam logic [DOE_W-1:0] ERA_LAST = 18'd146096;

    // reciprocal for the era split, floor(2^48 / 146097)
    localparam logic [31:0] ERA_RECIP = 32'((64'd1 << 48) / 64'd146097);

    // rounded-up reciprocals, exact over the argument ranges below
    localparam int DIV7_SH     = 21;
    localparam logic [31:0] DIV7_MUL = 32'(((64'd1 << DIV7_SH) + 64'd6) / 64'd7);
    localparam int DIV1460_SH  = 29;
    localparam logic [31:0] DIV1460_MUL =
        32'(((64'd1 << DIV1460_SH) + 64'd1459) / 64'd1460);
    localparam int DIV36524_SH = 34;
    localparam logic [31:0] DIV36524_MUL =
        32'(((64'd1 << DIV36524_SH) + 64'd36523) / 64'd36524);
    localparam int DIV365_SH   = 27;
    localparam logic [31:0] DIV365_MUL =
        32'(((64'd1 << DIV365_SH) + 64'd364) / 64'd365);
    localparam int DIV100_SH   = 16;
    localparam logic [31:0] DIV100_MUL =
        32'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
    localparam int DIV153_SH   = 19;
    localparam logic [31:0] DIV153_MUL =
        32'(((64'd1 << DIV153_SH) + 64'd152) / 64'd153);

    // march-based month index of january
    localparam logic [3:0] MP_JAN = 4'd10;

    // x / 7 for x below 2^18
    function automatic logic [17:0] div7_u18(input logic [17:0] x);
        logic [49:0] prod;
        prod = 50'(x) * 50'(DIV7_MUL);
        return 18'(prod >> DIV7_SH);
    endfunction

    // x / 1460 for x below 2^18
    function automatic logic [17:0] div1460_u18(input logic [17:0] x);
        logic [49:0] prod;
        prod = 50'(x) * 50'(DIV1460_MUL);
        return 18'(prod >> DIV1460_SH);
    endfunction

    // x / 36524 for x below 2^18
    function automatic logic [17:0] div36524_u18(input logic [17:0] x);
        logic [49:0] prod;
        prod = 50'(x) * 50'(DIV36524_MUL);
        return 18'(prod >> DIV36524_SH);
    endfunction

    // x / 365 for x below 2^18
    function automatic logic [17:0] div365_u18(input logic [17:0] x);
        logic [49:0] prod;
        prod = 50'(x) * 50'(DIV365_MUL);
        return 18'(prod >> DIV365_SH);
    endfunction

    // x / 100 for x below 2^9
    function automatic logic [8:0] div100_u9(input logic [8:0] x);
        logic [40:0] prod;
        prod = 41'(x) * 41'(DIV100_MUL);
        return 9'(prod >> DIV100_SH);
    endfunction

    // x / 153 for x below 2^11, quotient 0..13
    function automatic logic [3:0] div153_u11(input logic [10:0] x);
        logic [42:0] prod;
        prod = 43'(x) * 43'(DIV153_MUL);
        return 4'(prod >> DIV153_SH);
    endfunction

    // first day of a march-based month within the march-based year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

// ----- design/dcdiw_era_split.sv -----
// -----------------------------------------------------------------------------
// dcdiw_era_split
// Splits a signed day count into a 400-year era and the day within the era.
// -----------------------------------------------------------------------------
module dcdiw_era_split #(
    parameter int DAY_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [DAY_BITS-1:0]              day_in,
    output logic [dcdiw_pkg::DOE_W-1:0]      doe,
    output logic [DAY_BITS-15:0]             era
);
    import dcdiw_pkg::*;

    localparam int UB = DAY_BITS + 2;     // biased day count, always positive
    localparam int HB = UB - 16;          // upper part used for the estimate
    localparam int QB = DAY_BITS - 15;    // era quotient before unbiasing
    localparam int EB = DAY_BITS - 14;    // signed era
    localparam int PB = HB + 32;
    localparam int RB = DOE_W + 1;        // remainder before correction, < 3 eras
    localparam int MB = QB + DOE_W;

    localparam logic [EB-1:0] ERA_BIAS = EB'(64'd1 << (DAY_BITS - 17));
    localparam logic [UB-1:0] U_BIAS   =
        UB'((64'd146097 << (DAY_BITS - 17)) + 64'd719468);
    localparam logic [RB-1:0] ONE_ERA  = {1'b0, ERA_DAYS};
    localparam logic [RB-1:0] TWO_ERA  = {ERA_DAYS, 1'b0};

    logic [UB-1:0]    u_reg;
    logic [UB-1:0]    u_next;
    logic [PB-1:0]    est_prod;
    logic [QB-1:0]    q0_reg;
    logic [RB-1:0]    ulo_reg;
    logic [MB-1:0]    back_prod;
    logic [RB-1:0]    r_next;
    logic [RB-1:0]    r_reg;
    logic [QB-1:0]    q1_reg;
    logic [QB-1:0]    q_fix;
    logic [RB-1:0]    r_fix;
    logic [DOE_W-1:0] doe_reg;
    logic [EB-1:0]    era_reg;
    logic [EB-1:0]    era_next;

    assign u_next    = {{2{day_in[DAY_BITS-1]}}, day_in} + U_BIAS;
    assign est_prod  = PB'(u_reg[UB-1:16]) * PB'(ERA_RECIP);
    assign back_prod = MB'(q0_reg) * MB'(ERA_DAYS);
    assign r_next    = ulo_reg - back_prod[RB-1:0];

    // estimate is low by at most two eras
    always_comb begin
        if (r_reg >= TWO_ERA) begin
            r_fix = r_reg - TWO_ERA;
            q_fix = q1_reg + QB'(2);
        end else if (r_reg >= ONE_ERA) begin
            r_fix = r_reg - ONE_ERA;
            q_fix = q1_reg + QB'(1);
        end else begin
            r_fix = r_reg;
            q_fix = q1_reg;
        end
    end

    assign era_next = {1'b0, q_fix} - ERA_BIAS;

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg   <= u_next;
            q0_reg  <= est_prod[QB+31:32];
            ulo_reg <= u_reg[RB-1:0];
            r_reg   <= r_next;
            q1_reg  <= q0_reg;
            doe_reg <= r_fix[DOE_W-1:0];
            era_reg <= era_next;
        end
    end

    assign doe = doe_reg;
    assign era = era_reg;

endmodule

// ----- design/dcdiw_week_align.sv -----
// -----------------------------------------------------------------------------
// dcdiw_week_align
// Finds the thursday of the day's week, as era and day within the era.
// -----------------------------------------------------------------------------
module dcdiw_week_align #(
    parameter int ERA_W = 18
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [dcdiw_pkg::DOE_W-1:0] doe_in,
    input  logic [ERA_W-1:0]            era_in,
    output logic [dcdiw_pkg::DOE_W-1:0] doe_day,
    output logic [ERA_W-1:0]            era_day,
    output logic [dcdiw_pkg::DOE_W-1:0] doe_thu,
    output logic [ERA_W-1:0]            era_thu
);
    import dcdiw_pkg::*;

    localparam int TB = DOE_W + 1;

    logic [DOE_W-1:0] wd_arg;
    logic [DOE_W-1:0] q7;
    logic [DOE_W-1:0] seven_q;
    logic [2:0]       wd_next;
    logic [2:0]       wd_reg;
    logic [DOE_W-1:0] doe_a_reg;
    logic [ERA_W-1:0] era_a_reg;
    logic [TB-1:0]    td;
    logic [TB-1:0]    td_fix;
    logic [ERA_W-1:0] era_t_next;
    logic [DOE_W-1:0] doe_b_reg;
    logic [ERA_W-1:0] era_b_reg;
    logic [DOE_W-1:0] doe_t_reg;
    logic [ERA_W-1:0] era_t_reg;

    // an era is a whole number of weeks, so the weekday follows from doe alone
    assign wd_arg  = doe_in + DOE_W'(2);
    assign q7      = div7_u18(wd_arg);
    assign seven_q = {q7[DOE_W-4:0], 3'b000} - q7;
    assign wd_next = 3'(wd_arg - seven_q);

    assign td = {1'b0, doe_a_reg} + TB'(3) - TB'(wd_reg);

    // thursday may fall into the neighboring era
    always_comb begin
        if (td[TB-1]) begin
            td_fix     = td + {1'b0, ERA_DAYS};
            era_t_next = era_a_reg - ERA_W'(1);
        end else if (td >= {1'b0, ERA_DAYS}) begin
            td_fix     = td - {1'b0, ERA_DAYS};
            era_t_next = era_a_reg + ERA_W'(1);
        end else begin
            td_fix     = td;
            era_t_next = era_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wd_reg    <= wd_next;
            doe_a_reg <= doe_in;
            era_a_reg <= era_in;
            doe_b_reg <= doe_a_reg;
            era_b_reg <= era_a_reg;
            doe_t_reg <= td_fix[DOE_W-1:0];
            era_t_reg <= era_t_next;
        end
    end

    assign doe_day = doe_b_reg;
    assign era_day = era_b_reg;
    assign doe_thu = doe_t_reg;
    assign era_thu = era_t_reg;

endmodule

// ----- design/dcdiw_civil.sv -----
// -----------------------------------------------------------------------------
// dcdiw_civil
// Turns era and day within the era into year, month, day and the day's
// zero-based place in its calendar year.
// -----------------------------------------------------------------------------
module dcdiw_civil #(
    parameter int ERA_W = 18,
    parameter int YR_W  = 27
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [dcdiw_pkg::DOE_W-1:0]   doe_in,
    input  logic [ERA_W-1:0]              era_in,
    output logic [YR_W-1:0]               year,
    output logic [dcdiw_pkg::MONTH_W-1:0] month,
    output logic [dcdiw_pkg::MDAY_W-1:0]  mday,
    output logic [8:0]                    ord
);
    import dcdiw_pkg::*;

    // stage 1: leap-day corrected day count
    logic [DOE_W-1:0] n_next;
    logic [DOE_W-1:0] n_reg;
    logic [DOE_W-1:0] doe1_reg;
    logic [ERA_W-1:0] era1_reg;
    // stage 2: year of era
    logic [8:0]       yoe2_reg;
    logic [DOE_W-1:0] doe2_reg;
    logic [ERA_W-1:0] era2_reg;
    // stage 3: day of march-based year
    logic [DOE_W-1:0] yr_days;
    logic [8:0]       doy3_reg;
    logic [8:0]       yoe3_reg;
    logic [ERA_W-1:0] era3_reg;
    // stage 4: march-based month
    logic [10:0]      mp_arg;
    logic [3:0]       mp4_reg;
    logic [8:0]       doy4_reg;
    logic [8:0]       yoe4_reg;
    logic [ERA_W-1:0] era4_reg;
    // stage 5: calendar fields
    logic             jan_feb;
    logic             leap;
    logic [YR_W-1:0]  era_sx;
    logic [YR_W-1:0]  year_next;
    logic [3:0]       month_next;
    logic [4:0]       mday_next;
    logic [8:0]       ord_next;
    logic [YR_W-1:0]  year_reg;
    logic [3:0]       month_reg;
    logic [4:0]       mday_reg;
    logic [8:0]       ord_reg;

    assign n_next = doe_in - div1460_u18(doe_in) + div36524_u18(doe_in)
                    - DOE_W'(doe_in == ERA_LAST);

    assign yr_days = DOE_W'(yoe2_reg) * DOE_W'(365) + DOE_W'(yoe2_reg[8:2])
                     - DOE_W'(div100_u9(yoe2_reg));

    assign mp_arg = {doy3_reg, 2'b00} + 11'(doy3_reg) + 11'd2;

    assign jan_feb = (mp4_reg >= MP_JAN);
    assign leap    = (yoe4_reg[1:0] == 2'b00) && (yoe4_reg != 9'd100)
                     && (yoe4_reg != 9'd200) && (yoe4_reg != 9'd300);
    assign era_sx  = {{(YR_W-ERA_W){era4_reg[ERA_W-1]}}, era4_reg};

    always_comb begin
        year_next  = YR_W'(yoe4_reg) + (era_sx << 8) + (era_sx << 7) + (era_sx << 4)
                     + YR_W'(jan_feb);
        month_next = jan_feb ? (mp4_reg - 4'd9) : (mp4_reg + 4'd3);
        mday_next  = 5'(doy4_reg - month_start(mp4_reg) + 9'd1);
        ord_next   = jan_feb ? (doy4_reg - 9'd306) : (doy4_reg + 9'd59 + 9'(leap));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg     <= n_next;
            doe1_reg  <= doe_in;
            era1_reg  <= era_in;
            yoe2_reg  <= 9'(div365_u18(n_reg));
            doe2_reg  <= doe1_reg;
            era2_reg  <= era1_reg;
            doy3_reg  <= 9'(doe2_reg - yr_days);
            yoe3_reg  <= yoe2_reg;
            era3_reg  <= era2_reg;
            mp4_reg   <= div153_u11(mp_arg);
            doy4_reg  <= doy3_reg;
            yoe4_reg  <= yoe3_reg;
            era4_reg  <= era3_reg;
            year_reg  <= year_next;
            month_reg <= month_next;
            mday_reg  <= mday_next;
            ord_reg   <= ord_next;
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign mday  = mday_reg;
    assign ord   = ord_reg;

endmodule

// ----- design/dcdiw_result.sv -----
// -----------------------------------------------------------------------------
// dcdiw_result
// Result register: calendar fields of the day and the iso week of its thursday.
// -----------------------------------------------------------------------------
module dcdiw_result #(
    parameter int YR_W = 27
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [YR_W-1:0]               day_year,
    input  logic [dcdiw_pkg::MONTH_W-1:0] day_month,
    input  logic [dcdiw_pkg::MDAY_W-1:0]  day_mday,
    input  logic [YR_W-1:0]               thu_year,
    input  logic [8:0]                    thu_ord,
    output logic [dcdiw_pkg::YEAR_W-1:0]  cal_year,
    output logic [dcdiw_pkg::MONTH_W-1:0] cal_month,
    output logic [dcdiw_pkg::MDAY_W-1:0]  cal_day,
    output logic [dcdiw_pkg::WYEAR_W-1:0] iso_week_year,
    output logic [dcdiw_pkg::WEEK_W-1:0]  iso_week,
    output logic                          week_valid
);
    import dcdiw_pkg::*;

    logic               wk_ok;
    logic [WEEK_W-1:0]  week_num;
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [MDAY_W-1:0]  mday_reg;
    logic [WYEAR_W-1:0] wyear_next;
    logic [WYEAR_W-1:0] wyear_reg;
    logic [WEEK_W-1:0]  week_next;
    logic [WEEK_W-1:0]  week_reg;
    logic               valid_reg;

    assign wk_ok      = !thu_year[YR_W-1] && (thu_year != '0);
    assign week_num   = WEEK_W'(div7_u18(DOE_W'(thu_ord)) + DOE_W'(1));
    assign wyear_next = wk_ok ? thu_year[WYEAR_W-1:0] : '0;
    assign week_next  = wk_ok ? week_num : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            year_reg  <= day_year[YEAR_W-1:0];
            month_reg <= day_month;
            mday_reg  <= day_mday;
            wyear_reg <= wyear_next;
            week_reg  <= week_next;
            valid_reg <= wk_ok;
        end
    end

    assign cal_year      = year_reg;
    assign cal_month     = month_reg;
    assign cal_day       = mday_reg;
    assign iso_week_year = wyear_reg;
    assign iso_week      = week_reg;
    assign week_valid    = valid_reg;

endmodule

// ----- design/day_count_to_date_and_iso_week_core.sv -----
// -----------------------------------------------------------------------------
// day_count_to_date_and_iso_week_core
// Signed day count (day 0 = 1970-01-01) to proleptic gregorian date and iso
// week, one transaction per clock while the output is accepted.
// -----------------------------------------------------------------------------
// The core takes one day count per cycle while the pipe advances and returns
// its year, month and day plus the iso week-year and week number of that day's
// week. It is a 13-register pipeline: input register, four stages to split
// the count into 400-year eras (a reciprocal multiply with a two-step
// remainder fix), two stages to find the week's thursday, five stages of date
// arithmetic run side by side for the day and for the thursday, and
// the result register. No stage chains more than one constant multiply. All
// stages move together: the pipe advances whenever the result register is
// empty or its transaction is taken, so s_tready = !m_tvalid || m_tready and
// a new day count can enter on every cycle that the downstream side accepts.
// When the thursday's year is zero or negative the week fields read zero and
// m_tuser is low; the date fields are always valid. Nothing is kept between
// transactions, and reset only empties the pipeline.
// -----------------------------------------------------------------------------
module day_count_to_date_and_iso_week_core #(
    parameter int DAY_BITS = dcdiw_pkg::DAY_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // day count in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((DAY_BITS+7)/8)*8-1:0]       s_tdata,   // day_count, zero pad
    // date and week out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cal_year[23:0], cal_month[27:24], cal_day[32:28], iso_week_year[55:33],
    // iso_week[61:56], zero pad
    output logic [dcdiw_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [0:0]                          m_tuser    // week_valid
);
    import dcdiw_pkg::*;

    localparam int ERA_W = DAY_BITS - 14;
    localparam int YR_W  = (ERA_W + 9 > YEAR_W + 1) ? (ERA_W + 9) : (YEAR_W + 1);
    localparam int LAT   = 13;
    localparam int PAD_W = OUT_TDATA_W - (YEAR_W + MONTH_W + MDAY_W + WYEAR_W + WEEK_W);

    // pipeline control
    logic             adv;
    logic [LAT-1:0]   vld_reg;
    logic [LAT-1:0]   vld_next;

    // input register
    logic [DAY_BITS-1:0] day_reg;

    // era split and thursday
    logic [DOE_W-1:0] doe;
    logic [ERA_W-1:0] era;
    logic [DOE_W-1:0] doe_day;
    logic [ERA_W-1:0] era_day;
    logic [DOE_W-1:0] doe_thu;
    logic [ERA_W-1:0] era_thu;

    // calendar of the day and of its thursday
    logic [YR_W-1:0]    day_year;
    logic [MONTH_W-1:0] day_month;
    logic [MDAY_W-1:0]  day_mday;
    logic [8:0]         day_ord;
    logic [YR_W-1:0]    thu_year;
    logic [MONTH_W-1:0] thu_month;
    logic [MDAY_W-1:0]  thu_mday;
    logic [8:0]         thu_ord;

    // result fields
    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [MDAY_W-1:0]  cal_day;
    logic [WYEAR_W-1:0] iso_week_year;
    logic [WEEK_W-1:0]  iso_week;
    logic               week_valid;

    // whole pipe shifts when the result register is free or being drained
    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            day_reg <= s_tdata[DAY_BITS-1:0];
        end
    end

    dcdiw_era_split #(
        .DAY_BITS (DAY_BITS)
    ) u_era_split (
        .aclk   (aclk),
        .en     (adv),
        .day_in (day_reg),
        .doe    (doe),
        .era    (era)
    );

    dcdiw_week_align #(
        .ERA_W (ERA_W)
    ) u_week_align (
        .aclk    (aclk),
        .en      (adv),
        .doe_in  (doe),
        .era_in  (era),
        .doe_day (doe_day),
        .era_day (era_day),
        .doe_thu (doe_thu),
        .era_thu (era_thu)
    );

    // calendar date of the day itself
    dcdiw_civil #(
        .ERA_W (ERA_W),
        .YR_W  (YR_W)
    ) u_civil_day (
        .aclk   (aclk),
        .en     (adv),
        .doe_in (doe_day),
        .era_in (era_day),
        .year   (day_year),
        .month  (day_month),
        .mday   (day_mday),
        .ord    (day_ord)
    );

    // calendar date of the thursday, which fixes the week-year
    dcdiw_civil #(
        .ERA_W (ERA_W),
        .YR_W  (YR_W)
    ) u_civil_thu (
        .aclk   (aclk),
        .en     (adv),
        .doe_in (doe_thu),
        .era_in (era_thu),
        .year   (thu_year),
        .month  (thu_month),
        .mday   (thu_mday),
        .ord    (thu_ord)
    );

    dcdiw_result #(
        .YR_W (YR_W)
    ) u_result (
        .aclk          (aclk),
        .en            (adv),
        .day_year      (day_year),
        .day_month     (day_month),
        .day_mday      (day_mday),
        .thu_year      (thu_year),
        .thu_ord       (thu_ord),
        .cal_year      (cal_year),
        .cal_month     (cal_month),
        .cal_day       (cal_day),
        .iso_week_year (iso_week_year),
        .iso_week      (iso_week),
        .week_valid    (week_valid)
    );

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {{PAD_W{1'b0}}, iso_week, iso_week_year, cal_day, cal_month,
                       cal_year};
    assign m_tuser  = week_valid;

    // a valid week is numbered 1 to 53 and has a positive week-year
    a_week_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && week_valid) |-> ((iso_week != '0) && (iso_week <= 6'd53)
                                      && (iso_week_year != '0)))
        else $error("valid iso week out of range");

    // an invalid week carries zero week fields
    a_week_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !week_valid) |-> ((iso_week == '0) && (iso_week_year == '0)))
        else $error("invalid iso week has nonzero fields");

    // the thursday lies at most three days from the day, so their months
    // differ by at most one step around the year
    a_thu_month: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LAT-2] |-> ((day_month >= 4'd1) && (day_month <= 4'd12)
                            && (thu_mday >= 5'd1) && (thu_mday <= 5'd31)
                            && ((thu_month == day_month)
                                || (thu_month == day_month + 4'd1)
                                || (thu_month == day_month - 4'd1)
                                || ((thu_month == 4'd1) && (day_month == 4'd12))
                                || ((thu_month == 4'd12) && (day_month == 4'd1)))
                            && (day_ord <= 9'd365)))
        else $error("thursday date inconsistent with day date");

endmodule
